[hw/rtl/fexp_pkg.sv]
// shared types, constants and arithmetic helpers of the float32 exp unit
`default_nettype none

package fexp_pkg;

  localparam int N_CELLS = 12;

  // binary32 constants
  localparam logic [31:0] F_MAGIC_BIAS  = 32'h4B40_0000;
  localparam logic [31:0] F_NEG_MAGIC   = 32'hCB40_0000;
  localparam logic [31:0] F_ONE         = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ZERO    = 32'h8000_0000;
  localparam logic [31:0] F_INF         = 32'h7F80_0000;
  localparam logic [31:0] F_ZERO_CUTOFF = 32'hC2CF_F1B4;
  localparam logic [31:0] F_INF_CUTOFF  = 32'h42B1_7217;
  localparam logic [31:0] F_LOG2E       = 32'h3FB8_AA3B;
  localparam logic [31:0] F_NEG_LN2_HI  = 32'hBF31_7200;
  localparam logic [31:0] F_NEG_LN2_LO  = 32'hB5BF_BE8E;
  localparam logic [31:0] F_C2          = 32'h3EFF_FFFE;
  localparam logic [31:0] F_C3          = 32'h3E2A_AA46;
  localparam logic [31:0] F_C4          = 32'h3D2A_AC1A;
  localparam logic [31:0] F_C5          = 32'h3C09_1E7F;
  localparam logic [31:0] F_C6          = 32'h3AB5_6E57;

  // values that travel alongside a request from cell to cell
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] t;
    logic [31:0] r;
    logic [31:0] s1;
    logic [31:0] s2;
  } fexp_ctx_t;

  // normalized, unrounded value: hidden bit at m[25], guard m[1], sticky m[0]
  typedef struct packed {
    logic               sign;
    logic               zero;
    logic signed [10:0] e;
    logic [25:0]        m;
  } fexp_unr_t;

  function automatic logic [5:0] f_lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] f_lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

  // round to nearest even, with gradual underflow and overflow to infinity
  function automatic logic [31:0] f_round(input fexp_unr_t u);
    logic [25:0]        m;
    logic [7:0]         ef;
    logic signed [10:0] sh11;
    logic [4:0]         sh;
    logic               inc;
    logic [31:0]        res;
    m    = u.m;
    ef   = '0;
    sh11 = 11'sd1 - u.e;
    sh   = sh11[4:0];
    if (u.zero) begin
      res = {u.sign, 31'b0};
    end else if (u.e >= 11'sd255) begin
      res = {u.sign, 8'hFF, 23'b0};
    end else begin
      if (u.e <= 11'sd0) begin
        if (u.e < -11'sd24) begin
          m = {25'b0, |u.m};
        end else begin
          m = (u.m >> sh) | {25'b0, |(u.m & ~({26{1'b1}} << sh))};
        end
      end else begin
        ef = u.e[7:0];
      end
      inc = m[1] & (m[0] | m[2]);
      res = {u.sign, {ef, m[24:2]} + {30'b0, inc}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fexp_cell.sv]
// one binary32 multiply-then-add cell, seven pipeline stages, separate roundings
`default_nettype none

module fexp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_a,
  input  logic [31:0]         in_b,
  input  logic [31:0]         in_c,
  input  fexp_pkg::fexp_ctx_t in_ctx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_res,
  output fexp_pkg::fexp_ctx_t out_ctx
);
  import fexp_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   ld;
  fexp_ctx_t         ctx_r [STAGES];

  // stage 0: mantissa product
  logic [47:0] s0_p_r;
  logic [9:0]  s0_esum_r;
  logic        s0_sign_r;
  logic [31:0] s0_c_r;
  // stage 1: product normalized
  fexp_unr_t   s1_u_r;
  logic [31:0] s1_c_r;
  // stage 2: product rounded
  logic [31:0] s2_prod_r;
  logic [31:0] s2_c_r;
  // stage 3: operands aligned
  logic        s3_sign_r;
  logic        s3_sub_r;
  logic [7:0]  s3_e_r;
  logic [26:0] s3_mb_r;
  logic [26:0] s3_ms_r;
  // stage 4: sum
  logic        s4_sign_r;
  logic        s4_sub_r;
  logic [7:0]  s4_e_r;
  logic [27:0] s4_sum_r;
  // stage 5: sum normalized
  fexp_unr_t   s5_u_r;
  // stage 6: result
  logic [31:0] s6_res_r;

  always_comb begin
    ld[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[STAGES-1];
  assign out_res   = s6_res_r;
  assign out_ctx   = ctx_r[STAGES-1];

  // multiply
  logic [7:0]  a_e, b_e;
  logic [23:0] a_m, b_m;
  logic [47:0] p_nxt;
  logic [9:0]  esum_nxt;

  always_comb begin
    a_e      = (in_a[30:23] == 8'd0) ? 8'd1 : in_a[30:23];
    b_e      = (in_b[30:23] == 8'd0) ? 8'd1 : in_b[30:23];
    a_m      = {|in_a[30:23], in_a[22:0]};
    b_m      = {|in_b[30:23], in_b[22:0]};
    p_nxt    = a_m * b_m;
    esum_nxt = {2'b0, a_e} + {2'b0, b_e};
  end

  // product normalize
  logic [5:0]  plz;
  logic [47:0] pn;
  fexp_unr_t   pu_nxt;

  always_comb begin
    plz         = f_lzc48(s0_p_r);
    pn          = s0_p_r << plz;
    pu_nxt.sign = s0_sign_r;
    pu_nxt.zero = (s0_p_r == 48'd0);
    pu_nxt.e    = $signed({1'b0, s0_esum_r}) - 11'sd126 - $signed({5'b0, plz});
    pu_nxt.m    = {pn[47:23], |pn[22:0]};
  end

  // align the smaller operand
  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  big_e, sml_e, diff;
  logic [26:0] sml_full, ms_nxt;

  always_comb begin
    swap     = s2_c_r[30:0] > s2_prod_r[30:0];
    big      = swap ? s2_c_r : s2_prod_r;
    sml      = swap ? s2_prod_r : s2_c_r;
    big_e    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    sml_e    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff     = big_e - sml_e;
    sml_full = {|sml[30:23], sml[22:0], 3'b000};
    if (diff >= 8'd27) begin
      ms_nxt = {26'b0, |sml_full};
    end else begin
      ms_nxt = (sml_full >> diff) | {26'b0, |(sml_full & ~({27{1'b1}} << diff))};
    end
  end

  // sum normalize
  logic [4:0]  slz;
  logic [27:0] sn;
  fexp_unr_t   su_nxt;

  always_comb begin
    slz         = f_lzc28(s4_sum_r);
    sn          = s4_sum_r << slz;
    su_nxt.zero = (s4_sum_r == 28'd0);
    // exact cancellation gives +0
    su_nxt.sign = su_nxt.zero ? (s4_sign_r & !s4_sub_r) : s4_sign_r;
    su_nxt.e    = $signed({3'b0, s4_e_r}) + 11'sd1 - $signed({6'b0, slz});
    su_nxt.m    = {sn[27:3], |sn[2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) ctx_r[0] <= in_ctx;
    for (int i = 1; i < STAGES; i++) begin
      if (ld[i]) ctx_r[i] <= ctx_r[i-1];
    end
    if (ld[0]) begin
      s0_p_r    <= p_nxt;
      s0_esum_r <= esum_nxt;
      s0_sign_r <= in_a[31] ^ in_b[31];
      s0_c_r    <= in_c;
    end
    if (ld[1]) begin
      s1_u_r <= pu_nxt;
      s1_c_r <= s0_c_r;
    end
    if (ld[2]) begin
      s2_prod_r <= f_round(s1_u_r);
      s2_c_r    <= s1_c_r;
    end
    if (ld[3]) begin
      s3_sign_r <= big[31];
      s3_sub_r  <= big[31] ^ sml[31];
      s3_e_r    <= big_e;
      s3_mb_r   <= {|big[30:23], big[22:0], 3'b000};
      s3_ms_r   <= ms_nxt;
    end
    if (ld[4]) begin
      s4_sign_r <= s3_sign_r;
      s4_sub_r  <= s3_sub_r;
      s4_e_r    <= s3_e_r;
      s4_sum_r  <= s3_sub_r ? ({1'b0, s3_mb_r} - {1'b0, s3_ms_r})
                            : ({1'b0, s3_mb_r} + {1'b0, s3_ms_r});
    end
    if (ld[5]) s5_u_r   <= su_nxt;
    if (ld[6]) s6_res_r <= f_round(s5_u_r);
  end

endmodule

`default_nettype wire

[hw/rtl/float32_exp_unit.sv]
// top level of the pipelined binary32 e^x unit
`default_nettype none

//  channel   ports                             direction
//  ------    -------------------------------   ---------
//  input     in_valid / in_ready, in_x_bits    request in
//  result    out_valid / out_ready, out_exp_bits  request out
//
//  one request enters per cycle while the output is not stalled; the path runs
//  through twelve multiply-add cells of seven stages each, plus the output register
//  each pipeline stage has its own valid bit, so bubbles close up under a stall
//  and a new request is taken while a finished result waits at the output
//  synchronous active-low reset clears all valid bits; data registers keep junk

module float32_exp_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_exp_bits
);
  import fexp_pkg::*;

  logic        vld [N_CELLS+1];
  logic        rdy [N_CELLS+1];
  logic [31:0] cell_a   [N_CELLS];
  logic [31:0] cell_b   [N_CELLS];
  logic [31:0] cell_c   [N_CELLS];
  logic [31:0] cell_res [N_CELLS];
  fexp_ctx_t   ctx_in   [N_CELLS];
  fexp_ctx_t   ctx_out  [N_CELLS];

  // scale factors from k in the low mantissa bits of t
  logic signed [8:0] k, k_clamp, k_rest;
  logic [31:0]       s1_val, s2_val;

  always_comb begin
    k       = $signed(cell_res[0][8:0]);
    if (k < -9'sd126)     k_clamp = -9'sd126;
    else if (k > 9'sd127) k_clamp = 9'sd127;
    else                  k_clamp = k;
    k_rest  = k - k_clamp;
    s1_val  = {k_clamp, 23'b0} + F_ONE;
    s2_val  = {k_rest, 23'b0} + F_ONE;
  end

  // operand routing between cells
  always_comb begin
    ctx_in[0]   = '0;
    ctx_in[0].x = in_x_bits;
    for (int i = 1; i < N_CELLS; i++) begin
      ctx_in[i] = ctx_out[i-1];
    end
    ctx_in[1].s1 = s1_val;
    ctx_in[1].s2 = s2_val;
    ctx_in[2].t  = cell_res[1];
    ctx_in[4].r  = cell_res[3];

    // t = x*log2e + magic
    cell_a[0]  = in_x_bits;         cell_b[0]  = F_LOG2E;      cell_c[0]  = F_MAGIC_BIAS;
    // t - magic, times one is exact
    cell_a[1]  = cell_res[0];       cell_b[1]  = F_ONE;        cell_c[1]  = F_NEG_MAGIC;
    // two-step reduction
    cell_a[2]  = cell_res[1];       cell_b[2]  = F_NEG_LN2_HI; cell_c[2]  = ctx_in[2].x;
    cell_a[3]  = ctx_in[3].t;       cell_b[3]  = F_NEG_LN2_LO; cell_c[3]  = cell_res[2];
    // horner chain
    cell_a[4]  = cell_res[3];       cell_b[4]  = F_C6;         cell_c[4]  = F_C5;
    cell_a[5]  = ctx_in[5].r;       cell_b[5]  = cell_res[4];  cell_c[5]  = F_C4;
    cell_a[6]  = ctx_in[6].r;       cell_b[6]  = cell_res[5];  cell_c[6]  = F_C3;
    cell_a[7]  = ctx_in[7].r;       cell_b[7]  = cell_res[6];  cell_c[7]  = F_C2;
    // plain products add negative zero, which leaves them unchanged
    cell_a[8]  = ctx_in[8].r;       cell_b[8]  = cell_res[7];  cell_c[8]  = F_NEG_ZERO;
    cell_a[9]  = ctx_in[9].r;       cell_b[9]  = cell_res[8];  cell_c[9]  = ctx_in[9].r;
    // scale by 2^k in two factors
    cell_a[10] = ctx_in[10].s1;     cell_b[10] = cell_res[9];  cell_c[10] = ctx_in[10].s1;
    cell_a[11] = ctx_in[11].s2;     cell_b[11] = cell_res[10]; cell_c[11] = F_NEG_ZERO;
  end

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    fexp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_a      (cell_a[g]),
      .in_b      (cell_b[g]),
      .in_c      (cell_c[g]),
      .in_ctx    (ctx_in[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_res   (cell_res[g]),
      .out_ctx   (ctx_out[g])
    );
  end

  // special inputs override the computed value
  logic [31:0] x_last;
  logic        is_nan, is_low, is_high;
  logic [31:0] exp_nxt;

  always_comb begin
    x_last  = ctx_out[N_CELLS-1].x;
    is_nan  = x_last[30:0] > F_INF[30:0];
    is_low  = x_last[31] && (x_last[30:0] > F_ZERO_CUTOFF[30:0]);
    is_high = !x_last[31] && (x_last[30:0] > F_INF_CUTOFF[30:0]);
    if (is_nan)       exp_nxt = x_last;
    else if (is_high) exp_nxt = F_INF;
    else if (is_low)  exp_nxt = '0;
    else              exp_nxt = cell_res[N_CELLS-1];
  end

  // output register
  logic        out_valid_r;
  logic [31:0] out_exp_bits_r;

  assign rdy[N_CELLS] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[N_CELLS]) begin
      out_valid_r <= vld[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N_CELLS]) out_exp_bits_r <= exp_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_exp_bits = out_exp_bits_r;

endmodule

`default_nettype wire

[hw/rtl/fexp_checker.sv]
// port-level checks of the float32 exp unit and their binding
`default_nettype none

module fexp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_x_bits,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_exp_bits
);

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_x_bits))
    else $error("waiting request changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_exp_bits))
    else $error("stalled result changed");

  // e^x is never negative; only a passed-through nan carries a sign
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exp_bits[31] |->
      out_exp_bits[30:23] == 8'hFF && out_exp_bits[22:0] != 23'd0)
    else $error("negative non-nan result");

  // an empty output register lets the whole pipe move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind float32_exp_unit fexp_checker u_fexp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_x_bits    (in_x_bits),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_exp_bits (out_exp_bits)
);

`default_nettype wire

[test/float32_exp_unit_tb.sv]
// self-checking testbench of the float32 e^x unit
`timescale 1ns / 1ps

module float32_exp_unit_tb;
  import fexp_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 120;   // a little beyond the pipeline latency
  localparam int N_RANDOM    = 1700;
  localparam int N_BURST     = 220;
  localparam int LONG_HOLD   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_x_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_exp_bits;

  logic [31:0] exp_expected[$];
  int          n_errors;
  int          n_cycles;
  bit          send_idle;       // sender draws random gaps when set
  bit          recv_idle;       // receiver draws random stalls when set
  int          hold_request;    // long receiver hold-off, picked up by the receiver
  int          recv_stall;

  float32_exp_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x_bits    (in_x_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_exp_bits (out_exp_bits)
  );

  // free-running clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // binary32 arithmetic: every op is done in double, then rounded once to
  // binary32 nearest-even; double is wide enough that this equals a direct
  // binary32 rounding for a single add or multiply
  // ---------------------------------------------------------------------------

  function automatic real f32_to_real(input logic [31:0] f);
    logic [63:0] d;
    real         v;
    if (f[30:23] == 8'hFF) begin
      // inf keeps its sign, any nan becomes a quiet nan
      d = {f[31], 11'h7FF, (f[22:0] != 0), 51'b0};
      v = $bitstoreal(d);
    end else if (f[30:23] == 8'h00) begin
      // denormal or zero: mantissa times 2^-149, exact in double
      v = $itor(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'b0});
      if (f[31]) v = -v;
      if (f[22:0] == 0) v = $bitstoreal({f[31], 63'b0});
    end else begin
      d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0};
      v = $bitstoreal(d);
    end
    return v;
  endfunction

  function automatic logic [31:0] real_to_f32(input real v);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rest;
    logic [63:0] half;
    int          ue;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, (d[51:0] != 0), 22'b0};
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    ue  = int'(d[62:52]) - 1023;
    if (ue > 127) return {d[63], 8'hFF, 23'b0};
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (ue >= -126) ? 29 : 29 + (-126 - ue);
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    rest = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
    if (ue < -126) begin
      // denormal; a carry into bit 23 lands exactly on the smallest normal
      return {d[63], kept[30:0]};
    end
    if (kept[24]) begin
      kept = kept >> 1;
      ue   = ue + 1;
    end
    if (ue > 127) return {d[63], 8'hFF, 23'b0};
    return {d[63], 8'(ue + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  // a*b + c, two roundings, never fused
  function automatic logic [31:0] fmadd(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return fadd(fmul(a, b), c);
  endfunction

  // ---------------------------------------------------------------------------
  // e^x predictor: magic-bias rounding, two-step ln2 reduction, degree-6
  // polynomial, scale by 2^k split into a clamped and a leftover factor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] exp_predict(input logic [31:0] xb);
    logic [31:0]        t;
    logic [31:0]        tk;
    logic [31:0]        e_all;
    logic signed [31:0] e_s;
    logic [31:0]        e1;
    logic [31:0]        e2;
    logic [31:0]        s1;
    logic [31:0]        s2;
    logic [31:0]        r;
    logic [31:0]        p;
    logic [31:0]        q;
    logic [31:0]        poly;
    logic [31:0]        res;
    real                xr;
    t     = fmadd(xb, F_LOG2E, F_MAGIC_BIAS);
    e_all = {t[8:0], 23'b0};
    e_s   = e_all;
    if (e_s < -32'sd126 * 32'sd8388608) e_s = -32'sd126 * 32'sd8388608;
    if (e_s >  32'sd127 * 32'sd8388608) e_s =  32'sd127 * 32'sd8388608;
    e1    = e_s;
    e2    = e_all - e1;
    s1    = e1 + F_ONE;
    s2    = e2 + F_ONE;

    tk    = fadd(t, F_NEG_MAGIC);
    r     = fmadd(tk, F_NEG_LN2_HI, xb);
    r     = fmadd(tk, F_NEG_LN2_LO, r);

    p     = fmadd(r, F_C6, F_C5);
    p     = fmadd(r, p, F_C4);
    p     = fmadd(r, p, F_C3);
    p     = fmadd(r, p, F_C2);
    q     = fmul(r, p);
    poly  = fmadd(r, q, r);
    res   = fmul(s2, fmadd(s1, poly, s1));

    // nan passes through untouched, cutoffs override everything else
    if ((xb & 32'h7FFF_FFFF) > F_INF) return xb;
    xr = f32_to_real(xb);
    if (xr < f32_to_real(F_ZERO_CUTOFF)) res = 32'h0000_0000;
    if (xr > f32_to_real(F_INF_CUTOFF))  res = F_INF;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: optional random gap, then hold the request until it is taken;
  // valid stays up after acceptance so back-to-back requests need no gap
  // ---------------------------------------------------------------------------
  task automatic send_x(input logic [31:0] xb);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_x_bits <= xb;
    do @(posedge clk); while (!in_ready);
    exp_expected.push_back(exp_predict(xb));
  endtask

  // drop valid, then wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_expected.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: exp_bits got %08h want %08h", n_cycles, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: short random stalls per result, or a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else if (hold_request > 0) begin
      out_ready    <= 1'b0;
      recv_stall   <= hold_request;
      hold_request <= 0;
    end else if (recv_stall > 0) begin
      out_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (out_valid && out_ready) begin
      // a result just went through: draw the stall before the next one
      if (recv_idle && $urandom_range(0, 1)) begin
        out_ready  <= 1'b0;
        recv_stall <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_expected.size() == 0) begin
        $display("unexpected result %08h at cycle %0d", out_exp_bits, n_cycles);
        n_errors++;
      end else begin
        if (out_exp_bits !== exp_expected[0]) report_mismatch(out_exp_bits, exp_expected[0]);
        void'(exp_expected.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // random operand shapes
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_in_range();
    // exponents 2^-27 .. 2^6: the interesting range, including denormal outputs
    return {1'($urandom), 8'($urandom_range(100, 133)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_edge();
    logic [31:0] b;
    case ($urandom_range(0, 5))
      0: b = {1'($urandom), 8'h00, 23'($urandom)};                  // denormal in
      1: b = F_ZERO_CUTOFF + 32'($urandom_range(0, 6)) - 32'd3;     // near zero cutoff
      2: b = F_INF_CUTOFF + 32'($urandom_range(0, 6)) - 32'd3;      // near inf cutoff
      3: b = {1'($urandom), 8'hFF, 23'($urandom)};                  // nan or inf
      4: b = {1'b1, 8'($urandom_range(133, 134)), 23'($urandom)};   // large negative, down to denormal and zero out
      default: b = {1'($urandom), 8'($urandom_range(134, 254)), 23'($urandom)};
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
             F_ONE, 32'hBF80_0000, 32'h3F31_7218, 32'h4B40_0000,
             F_ZERO_CUTOFF, F_ZERO_CUTOFF + 32'd1, F_ZERO_CUTOFF - 32'd1,
             F_INF_CUTOFF, F_INF_CUTOFF + 32'd1, F_INF_CUTOFF - 32'd1,
             F_INF, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
             32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'hC2B0_0000, 32'hC2C8_0000,
             32'hC2AE_0000, 32'hC2CF_0000};
    foreach (vals[i]) send_x(vals[i]);
  endtask

  task automatic test_random();
    int sel;
    for (int i = 0; i < N_RANDOM; i++) begin
      // every 200 requests, redraw whether sender and receiver idle
      if (i % 200 == 0) begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6)      send_x(rand_in_range());
      else if (sel < 8) send_x($urandom);
      else              send_x(rand_edge());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills up
  task automatic test_backpressure();
    send_idle    = 1'b0;
    hold_request = LONG_HOLD;
    for (int i = 0; i < N_BURST; i++) send_x(rand_in_range());
    send_idle = 1'b1;
  endtask

  // sender pauses until every result is back, then restarts
  task automatic test_drain_restart();
    wait_drained();
    for (int i = 0; i < 5; i++) send_x(rand_edge());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_x_bits    = '0;
    n_errors     = 0;
    n_cycles     = 0;
    hold_request = 0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_drain_restart();
    test_random();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0 && exp_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (exp_expected.size() != 0)
        $display("%0d results never arrived", exp_expected.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/fexp_pkg.sv
hw/rtl/fexp_cell.sv
hw/rtl/float32_exp_unit.sv
hw/rtl/fexp_checker.sv
test/float32_exp_unit_tb.sv
